/* hdl/rau_pkg.sv */
// ----------------------------------------------------------------------------
// rau_pkg
// shared codes and field widths of the rational arithmetic unit
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int OP_W      = 3;
  localparam int RES_NUM_W = 33;
  localparam int RES_DEN_W = 32;
  localparam int CMP_W     = 2;
  localparam int OUT_BITS  = RES_NUM_W + RES_DEN_W + CMP_W;
  localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8;
  localparam int OUT_PAD   = OUT_W - OUT_BITS;

  typedef logic [OP_W-1:0]  op_t;
  typedef logic [CMP_W-1:0] cmp_t;

  localparam op_t OP_ADD = 3'd0;
  localparam op_t OP_SUB = 3'd1;
  localparam op_t OP_MUL = 3'd2;
  localparam op_t OP_DIV = 3'd3;
  localparam op_t OP_CMP = 3'd4;

  localparam cmp_t CMP_LESS    = 2'd0;
  localparam cmp_t CMP_EQUAL   = 2'd1;
  localparam cmp_t CMP_GREATER = 2'd2;

endpackage

/* hdl/rational_arithmetic_unit.sv */
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Takes two signed fractions a_num/a_den and b_num/b_den and an operation
// (add, subtract, multiply, divide, compare) and returns one reduced fraction
// per item. Work is done one item at a time through narrow serial units: a
// shift-add multiplier forms three cross products one bit a cycle (add and
// subtract with equal denominators skip it), a binary GCD loop does one
// shift or subtract a cycle, and two restoring dividers work in step
// (skipped when the fraction is already reduced). A new item is taken as
// soon as the previous one has reached the output register, which holds it
// until the result side takes it.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit
  import rau_pkg::*;
#(
  parameter int OPERAND_BITS = 16
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       in_tvalid,
  output logic                                       in_tready,
  // a_num, a_den, b_num, b_den
  input  logic [((4*OPERAND_BITS+7)/8)*8-1:0]        in_tdata,
  // req_type
  input  logic [OP_W-1:0]                            in_tuser,
  output logic                                       out_tvalid,
  input  logic                                       out_tready,
  // res_num, res_den, cmp_result
  output logic [OUT_W-1:0]                           out_tdata,
  // den_zero
  output logic [0:0]                                 out_tuser
);

  localparam int OB   = OPERAND_BITS;
  localparam int PW   = 2 * OB;
  localparam int IW   = (2 * OB + 1 > 64) ? 64 : 2 * OB + 1;
  localparam int MC_W = $clog2(OB);
  localparam int DC_W = $clog2(IW);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_START  = 4'd1;
  localparam logic [3:0] S_MLOAD  = 4'd2;
  localparam logic [3:0] S_MSTEP  = 4'd3;
  localparam logic [3:0] S_MSTORE = 4'd4;
  localparam logic [3:0] S_FORM   = 4'd5;
  localparam logic [3:0] S_CHECK  = 4'd6;
  localparam logic [3:0] S_GCD    = 4'd7;
  localparam logic [3:0] S_DIV    = 4'd8;
  localparam logic [3:0] S_SIGN   = 4'd9;
  localparam logic [3:0] S_DONE   = 4'd10;

  logic [3:0]               state_r, state_nxt;
  logic                     out_valid_r, out_valid_nxt;

  op_t                      op_r, op_nxt;
  logic signed [OB-1:0]     an_r, an_nxt, ad_r, ad_nxt, bn_r, bn_nxt, bd_r, bd_nxt;
  logic [1:0]               slot_r, slot_nxt;
  logic [MC_W-1:0]          mcnt_r, mcnt_nxt;
  logic [OB-1:0]            mhi_r, mhi_nxt, mlo_r, mlo_nxt, mmc_r, mmc_nxt;
  logic                     mneg_r, mneg_nxt;
  logic signed [PW-1:0]     p_r [0:2];
  logic signed [PW-1:0]     p_nxt [0:2];
  logic signed [IW-1:0]     n_r, n_nxt, d_r, d_nxt;
  cmp_t                     cmp_r, cmp_nxt;
  logic                     dz_r, dz_nxt;
  logic [IW-1:0]            u_r, u_nxt, v_r, v_nxt, nm_r, nm_nxt, dm_r, dm_nxt;
  logic [IW-1:0]            rn_r, rn_nxt, rd_r, rd_nxt;
  logic [DC_W-1:0]          dcnt_r, dcnt_nxt;

  logic [RES_NUM_W-1:0]     out_num_r, out_num_nxt;
  logic [RES_DEN_W-1:0]     out_den_r, out_den_nxt;
  cmp_t                     out_cmp_r, out_cmp_nxt;
  logic                     out_dz_r, out_dz_nxt;

  logic signed [OB-1:0]     mx, my;
  logic [OB:0]              msum;
  logic [PW-1:0]            mprod;
  logic [IW:0]              tn, td;
  logic [IW-1:0]            n_mag, d_mag;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD{1'b0}}, out_cmp_r, out_den_r, out_num_r};
  assign out_tuser  = out_dz_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    op_nxt        = op_r;
    an_nxt        = an_r;
    ad_nxt        = ad_r;
    bn_nxt        = bn_r;
    bd_nxt        = bd_r;
    slot_nxt      = slot_r;
    mcnt_nxt      = mcnt_r;
    mhi_nxt       = mhi_r;
    mlo_nxt       = mlo_r;
    mmc_nxt       = mmc_r;
    mneg_nxt      = mneg_r;
    p_nxt         = p_r;
    n_nxt         = n_r;
    d_nxt         = d_r;
    cmp_nxt       = cmp_r;
    dz_nxt        = dz_r;
    u_nxt         = u_r;
    v_nxt         = v_r;
    nm_nxt        = nm_r;
    dm_nxt        = dm_r;
    rn_nxt        = rn_r;
    rd_nxt        = rd_r;
    dcnt_nxt      = dcnt_r;
    out_num_nxt   = out_num_r;
    out_den_nxt   = out_den_r;
    out_cmp_nxt   = out_cmp_r;
    out_dz_nxt    = out_dz_r;

    // multiplier operand select
    case (slot_r)
      2'd0: begin
        mx = an_r;
        my = (op_r == OP_MUL) ? bn_r : bd_r;
      end
      2'd1: begin
        mx = ad_r;
        my = bn_r;
      end
      default: begin
        mx = ad_r;
        my = (op_r == OP_DIV) ? bn_r : bd_r;
      end
    endcase

    msum  = {1'b0, mhi_r} + {1'b0, (mlo_r[0] ? mmc_r : {OB{1'b0}})};
    mprod = {mhi_r, mlo_r};
    n_mag = n_r[IW-1] ? (~n_r + 1'b1) : n_r;
    d_mag = d_r[IW-1] ? (~d_r + 1'b1) : d_r;
    tn    = {rn_r, nm_r[IW-1]};
    td    = {rd_r, dm_r[IW-1]};

    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt    = in_tuser;
          an_nxt    = in_tdata[OB-1:0];
          ad_nxt    = in_tdata[2*OB-1:OB];
          bn_nxt    = in_tdata[3*OB-1:2*OB];
          bd_nxt    = in_tdata[4*OB-1:3*OB];
          state_nxt = S_START;
        end
      end
      S_START: begin
        cmp_nxt  = CMP_LESS;
        dz_nxt   = 1'b0;
        slot_nxt = 2'd0;
        if ((op_r inside {OP_ADD, OP_SUB}) && ad_r == bd_r) begin
          // shared denominator
          n_nxt     = (op_r == OP_ADD) ? IW'(an_r) + IW'(bn_r) : IW'(an_r) - IW'(bn_r);
          d_nxt     = IW'(ad_r);
          state_nxt = S_CHECK;
        end else if (op_r inside {OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_CMP}) begin
          state_nxt = S_MLOAD;
        end else begin
          n_nxt     = '0;
          d_nxt     = IW'(1);
          state_nxt = S_DONE;
        end
      end
      S_MLOAD: begin
        mhi_nxt   = '0;
        mlo_nxt   = my[OB-1] ? (~my + 1'b1) : my;
        mmc_nxt   = mx[OB-1] ? (~mx + 1'b1) : mx;
        mneg_nxt  = mx[OB-1] ^ my[OB-1];
        mcnt_nxt  = '0;
        state_nxt = S_MSTEP;
      end
      S_MSTEP: begin
        mhi_nxt  = msum[OB:1];
        mlo_nxt  = {msum[0], mlo_r[OB-1:1]};
        mcnt_nxt = mcnt_r + 1'b1;
        if (mcnt_r == MC_W'(OB - 1)) begin
          state_nxt = S_MSTORE;
        end
      end
      S_MSTORE: begin
        p_nxt[slot_r] = mneg_r ? (~mprod + 1'b1) : mprod;
        if (slot_r == 2'd2) begin
          state_nxt = S_FORM;
        end else begin
          slot_nxt  = slot_r + 2'd1;
          state_nxt = S_MLOAD;
        end
      end
      S_FORM: begin
        state_nxt = S_CHECK;
        case (op_r)
          OP_ADD: begin
            n_nxt = IW'(p_r[0]) + IW'(p_r[1]);
            d_nxt = IW'(p_r[2]);
          end
          OP_SUB: begin
            n_nxt = IW'(p_r[0]) - IW'(p_r[1]);
            d_nxt = IW'(p_r[2]);
          end
          OP_MUL, OP_DIV: begin
            n_nxt = IW'(p_r[0]);
            d_nxt = IW'(p_r[2]);
          end
          default: begin
            if (p_r[0] < p_r[1]) begin
              cmp_nxt = CMP_LESS;
            end else if (p_r[0] == p_r[1]) begin
              cmp_nxt = CMP_EQUAL;
            end else begin
              cmp_nxt = CMP_GREATER;
            end
            n_nxt     = '0;
            d_nxt     = IW'(1);
            state_nxt = S_DONE;
          end
        endcase
      end
      S_CHECK: begin
        if (d_r == '0) begin
          dz_nxt    = 1'b1;
          state_nxt = S_DONE;
        end else if (n_r == '0) begin
          d_nxt     = IW'(1);
          state_nxt = S_DONE;
        end else begin
          u_nxt     = n_mag;
          v_nxt     = d_mag;
          nm_nxt    = n_mag;
          dm_nxt    = d_mag;
          state_nxt = S_GCD;
        end
      end
      S_GCD: begin
        // binary gcd, common powers of two taken out of the dividends at once
        if (!u_r[0] && !v_r[0]) begin
          u_nxt  = u_r >> 1;
          v_nxt  = v_r >> 1;
          nm_nxt = nm_r >> 1;
          dm_nxt = dm_r >> 1;
        end else if (!u_r[0]) begin
          u_nxt = u_r >> 1;
        end else if (!v_r[0]) begin
          v_nxt = v_r >> 1;
        end else if (u_r > v_r) begin
          u_nxt = u_r - v_r;
        end else if (v_r > u_r) begin
          v_nxt = v_r - u_r;
        end else if (u_r == IW'(1)) begin
          state_nxt = S_SIGN;
        end else begin
          rn_nxt    = '0;
          rd_nxt    = '0;
          dcnt_nxt  = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (tn >= {1'b0, u_r}) begin
          rn_nxt = IW'(tn - {1'b0, u_r});
          nm_nxt = {nm_r[IW-2:0], 1'b1};
        end else begin
          rn_nxt = tn[IW-1:0];
          nm_nxt = {nm_r[IW-2:0], 1'b0};
        end
        if (td >= {1'b0, u_r}) begin
          rd_nxt = IW'(td - {1'b0, u_r});
          dm_nxt = {dm_r[IW-2:0], 1'b1};
        end else begin
          rd_nxt = td[IW-1:0];
          dm_nxt = {dm_r[IW-2:0], 1'b0};
        end
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == DC_W'(IW - 1)) begin
          state_nxt = S_SIGN;
        end
      end
      S_SIGN: begin
        n_nxt     = n_r[IW-1] ? (~nm_r + 1'b1) : nm_r;
        d_nxt     = d_r[IW-1] ? (~dm_r + 1'b1) : dm_r;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_num_nxt   = RES_NUM_W'(n_r);
          out_den_nxt   = RES_DEN_W'(d_r);
          out_cmp_nxt   = cmp_r;
          out_dz_nxt    = dz_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    an_r      <= an_nxt;
    ad_r      <= ad_nxt;
    bn_r      <= bn_nxt;
    bd_r      <= bd_nxt;
    slot_r    <= slot_nxt;
    mcnt_r    <= mcnt_nxt;
    mhi_r     <= mhi_nxt;
    mlo_r     <= mlo_nxt;
    mmc_r     <= mmc_nxt;
    mneg_r    <= mneg_nxt;
    p_r       <= p_nxt;
    n_r       <= n_nxt;
    d_r       <= d_nxt;
    cmp_r     <= cmp_nxt;
    dz_r      <= dz_nxt;
    u_r       <= u_nxt;
    v_r       <= v_nxt;
    nm_r      <= nm_nxt;
    dm_r      <= dm_nxt;
    rn_r      <= rn_nxt;
    rd_r      <= rd_nxt;
    dcnt_r    <= dcnt_nxt;
    out_num_r <= out_num_nxt;
    out_den_r <= out_den_nxt;
    out_cmp_r <= out_cmp_nxt;
    out_dz_r  <= out_dz_nxt;
  end

endmodule
